// ----- hw/rtl/i2c_register_access_master_defines.svh -----
// ----------------------------------------------------------------------------
// i2c register access master assertion macros
// concurrent assertion forms used by i2cram_seq
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH
`define I2C_REGISTER_ACCESS_MASTER_DEFINES_SVH

// checked outside reset
`define I2CRAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked on every edge, reset included
`define I2CRAM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/i2cram_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cram_pkg
// types and constants shared by the i2c register access master
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cram_pkg;

  localparam logic [9:0] PhaseTicksReset = 10'd20;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_START     = 4'd1,
    ST_DEV_W     = 4'd2,
    ST_REG       = 4'd3,
    ST_DATA      = 4'd4,
    ST_RS_LOW    = 4'd5,
    ST_RS_HIGH   = 4'd6,
    ST_RS_START  = 4'd7,
    ST_DEV_R     = 4'd8,
    ST_READ      = 4'd9,
    ST_STOP_LOW  = 4'd10,
    ST_STOP_HIGH = 4'd11,
    ST_STOP_REL  = 4'd12
  } step_e;

  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic       sda_sample;
  } tick_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
    logic       device_nak;
    logic       register_nak;
    logic       data_nak;
  } res_t;

endpackage

// ----- hw/rtl/i2c_register_access_master.sv -----
// ----------------------------------------------------------------------------
// i2c_register_access_master
// i2c master for single register writes and reads, stepped one tick per item
// ----------------------------------------------------------------------------
// Every input transaction is one bus tick carrying a request and the sampled
// SDA level; it yields exactly one result with the SCL and SDA levels for
// that tick plus status. A tick is registered, stepped through the sequencer
// and lands in the output register, and a new tick is taken every clock as
// long as the output side keeps taking results. phase_ticks sets the ticks per
// SCL half period.
`timescale 1ns / 1ps

module i2c_register_access_master import i2cram_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [9:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_valid_i,
  input  logic       req_type_i,
  input  logic [6:0] device_address_i,
  input  logic [7:0] register_address_i,
  input  logic [7:0] write_value_i,
  input  logic       sda_sample_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_level_o,
  output logic       sda_release_o,
  output logic       busy_res_o,
  output logic       done_res_o,
  output logic [7:0] read_value_o,
  output logic       device_nak_o,
  output logic       register_nak_o,
  output logic       data_nak_o
);

  logic [9:0] phase_ticks_q;
  logic       s1_valid_q;
  tick_t      s1_tick_q;
  logic       out_valid_q;
  res_t       out_res_q;
  res_t       res;
  logic       adv;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= PhaseTicksReset;
    end else if (cfg_we_i) begin
      phase_ticks_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_tick_q <= '{req_valid:        req_valid_i,
                     req_type:         req_type_i,
                     device_address:   device_address_i,
                     register_address: register_address_i,
                     write_value:      write_value_i,
                     sda_sample:       sda_sample_i};
    end
  end

  i2cram_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .tick_i        (s1_tick_q),
    .phase_ticks_i (phase_ticks_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = out_res_q.scl_level;
  assign sda_release_o  = out_res_q.sda_release;
  assign busy_res_o     = out_res_q.busy_res;
  assign done_res_o     = out_res_q.done_res;
  assign read_value_o   = out_res_q.read_value;
  assign device_nak_o   = out_res_q.device_nak;
  assign register_nak_o = out_res_q.register_nak;
  assign data_nak_o     = out_res_q.data_nak;

endmodule

// ----- hw/rtl/i2cram_seq.sv -----
// ----------------------------------------------------------------------------
// i2cram_seq
// bus sequencer: advances the i2c transaction by one tick per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_register_access_master_defines.svh"

module i2cram_seq import i2cram_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  tick_t      tick_i,
  input  logic [9:0] phase_ticks_i,
  output res_t       res_o
);

  step_e       state_q, state_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [3:0]  bit_q, bit_d;
  logic [7:0]  shift_q, shift_d;
  logic        hh_q, hh_d;
  logic [7:0]  rx_q, rx_d;
  logic [2:0]  ack_q, ack_d;
  logic        rd_q, rd_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  dat_q, dat_d;
  logic        done;
  logic        active;
  logic        byte_step;
  logic [9:0]  len;
  logic [10:0] cnt_inc;
  logic        phase_end;

  assign active    = state_q inside {[ST_START:ST_STOP_REL]};
  assign byte_step = state_q inside {ST_DEV_W, ST_REG, ST_DATA, ST_DEV_R, ST_READ};
  assign len       = (phase_ticks_i == 10'd0) ? 10'd1 : phase_ticks_i;
  assign cnt_inc   = {1'b0, cnt_q} + 11'd1;
  assign phase_end = cnt_inc >= {1'b0, len};

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    hh_d    = hh_q;
    rx_d    = rx_q;
    ack_d   = ack_q;
    rd_d    = rd_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    dat_d   = dat_q;
    done    = 1'b0;
    if (!active) begin
      state_d = ST_IDLE;
      if (tick_i.req_valid) begin
        rd_d    = tick_i.req_type;
        dev_d   = tick_i.device_address;
        reg_d   = tick_i.register_address;
        dat_d   = tick_i.write_value;
        ack_d   = 3'b000;
        cnt_d   = '0;
        bit_d   = '0;
        hh_d    = 1'b0;
        state_d = ST_START;
      end
    end else begin
      cnt_d = phase_end ? 10'd0 : cnt_inc[9:0];
      if (phase_end) begin
        if (byte_step) begin
          if (!hh_q) begin
            hh_d = 1'b1;
          end else begin
            hh_d = 1'b0;
            if (!bit_q[3]) begin
              shift_d = {shift_q[6:0], (state_q == ST_READ) & tick_i.sda_sample};
              bit_d   = bit_q + 4'd1;
            end else begin
              bit_d = '0;
              case (state_q)
                ST_DEV_W: begin
                  ack_d[2] = tick_i.sda_sample;
                  shift_d  = reg_q;
                  state_d  = ST_REG;
                end
                ST_REG: begin
                  ack_d[1] = tick_i.sda_sample;
                  if (rd_q) begin
                    state_d = ST_RS_LOW;
                  end else begin
                    shift_d = dat_q;
                    state_d = ST_DATA;
                  end
                end
                ST_DATA: begin
                  ack_d[0] = tick_i.sda_sample;
                  state_d  = ST_STOP_LOW;
                end
                ST_DEV_R: begin
                  ack_d[0] = tick_i.sda_sample;
                  shift_d  = 8'h00;
                  state_d  = ST_READ;
                end
                default: begin
                  rx_d    = shift_q;
                  state_d = ST_STOP_LOW;
                end
              endcase
            end
          end
        end else begin
          case (state_q)
            ST_START: begin
              shift_d = {dev_q, 1'b0};
              bit_d   = '0;
              hh_d    = 1'b0;
              state_d = ST_DEV_W;
            end
            ST_RS_LOW:  state_d = ST_RS_HIGH;
            ST_RS_HIGH: state_d = ST_RS_START;
            ST_RS_START: begin
              shift_d = {dev_q, 1'b1};
              bit_d   = '0;
              hh_d    = 1'b0;
              state_d = ST_DEV_R;
            end
            ST_STOP_LOW:  state_d = ST_STOP_HIGH;
            ST_STOP_HIGH: state_d = ST_STOP_REL;
            default: begin
              done    = 1'b1;
              state_d = ST_IDLE;
            end
          endcase
        end
      end
    end
  end

  // line levels and result
  always_comb begin
    res_o              = '0;
    res_o.scl_level    = 1'b1;
    res_o.sda_release  = 1'b1;
    res_o.busy_res     = 1'b1;
    case (state_q)
      ST_START:     res_o.sda_release = 1'b0;
      ST_RS_LOW:    res_o.scl_level   = 1'b0;
      ST_RS_HIGH:   res_o.sda_release = 1'b1;
      ST_RS_START:  res_o.sda_release = 1'b0;
      ST_STOP_LOW: begin
        res_o.scl_level   = 1'b0;
        res_o.sda_release = 1'b0;
      end
      ST_STOP_HIGH: res_o.sda_release = 1'b0;
      ST_STOP_REL:  res_o.sda_release = 1'b1;
      ST_DEV_W, ST_REG, ST_DATA, ST_DEV_R, ST_READ: begin
        res_o.scl_level   = hh_q;
        res_o.sda_release = (state_q == ST_READ) || bit_q[3] || shift_q[7];
      end
      default: res_o.busy_res = 1'b0;
    endcase
    res_o.done_res     = done;
    res_o.read_value   = rx_d;
    res_o.device_nak   = ack_d[2];
    res_o.register_nak = ack_d[1];
    res_o.data_nak     = ack_d[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      hh_q    <= 1'b0;
      rx_q    <= '0;
      ack_q   <= '0;
      rd_q    <= 1'b0;
      dev_q   <= '0;
      reg_q   <= '0;
      dat_q   <= '0;
    end else if (adv_i) begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      hh_q    <= hh_d;
      rx_q    <= rx_d;
      ack_q   <= ack_d;
      rd_q    <= rd_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      dat_q   <= dat_d;
    end
  end

  `I2CRAM_ASSERT(a_done_to_idle, (adv_i && done) |=> (state_q == ST_IDLE), "done without idle")
  `I2CRAM_ASSERT_ALWAYS(a_bit_range, bit_q <= 4'd8, "bit count past nine slots")
  `I2CRAM_ASSERT_ALWAYS(a_half_in_byte, !hh_q || byte_step, "high half outside a byte")
  `I2CRAM_ASSERT_ALWAYS(a_idle_cnt, active || (cnt_q == 10'd0), "phase count left over in idle")

endmodule
